### hw/rtl/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg: shared constants, types and tables for the transfer curve
// Sizes, register indexes, pipeline depth and the constant log-distance table
// used by the gamma / brightness / contrast curve and its checker.
// ----------------------------------------------------------------------------
package gbc_pkg;

   // Field sizes
   localparam int LEVEL_BITS  = 8;
   localparam int OUT_BITS    = 16;
   localparam int LEVEL_COUNT = 1 << LEVEL_BITS;
   localparam int LEVEL_MAX   = LEVEL_COUNT - 1;
   localparam int CFG_BITS    = 15;
   localparam int CSR_IDX_BITS = 2;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CFG_ENABLE     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CFG_EXPONENT   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CFG_BRIGHTNESS = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CFG_CONTRAST   = 2'd3;

   // Register reset values
   localparam logic [CFG_BITS-1:0] ONE_Q12 = 15'd4096;

   // Log distance (Q.16) and power (Q.16) widths
   localparam int DIST_BITS = LEVEL_BITS + 16;
   localparam int POW_BITS  = DIST_BITS + CFG_BITS - 12;

   // Square-root chain: 16 roots of 31 result bits, two bits per stage
   localparam int SQ_ROUNDS    = 16;
   localparam int SQ_BITS      = 31;
   localparam int SQ_PER_STAGE = 2;
   localparam int SQ_STAGES    = SQ_ROUNDS * SQ_BITS / SQ_PER_STAGE;

   // Accept edge to result transfer edge
   localparam int RSP_LATENCY = 3 + SQ_STAGES + 4;

   typedef logic [DIST_BITS-1:0] dist_table_type [LEVEL_COUNT];

   // log2 in Q.16 by successive squaring, elaboration only
   function automatic logic [31:0] lg_q16(input int unsigned v);
      int unsigned n;
      logic [63:0] m;
      logic [15:0] fr;
      n  = 0;
      fr = '0;
      for (int j = 0; j < 31; j++) begin
         if ((v >> (j + 1)) != 0) n = j + 1;
      end
      m = ({32'd0, v} << 16) >> n;
      for (int k = 0; k < 16; k++) begin
         m  = (m * m) >> 16;
         fr = {fr[14:0], (m >= 64'h20000)};
         if (m >= 64'h20000) m = m >> 1;
      end
      return (32'(n) << 16) | {16'd0, fr};
   endfunction

   // Distance lg(max) - lg(level), clipped at zero; zero for level 0
   function automatic dist_table_type build_dist_table();
      dist_table_type t;
      logic [31:0] lm;
      logic [31:0] ll;
      lm = lg_q16(LEVEL_MAX);
      for (int v = 0; v < LEVEL_COUNT; v++) begin
         ll = lg_q16(v);
         if (v == 0 || ll >= lm) t[v] = '0;
         else t[v] = DIST_BITS'(lm - ll);
      end
      return t;
   endfunction

   localparam dist_table_type DIST_TABLE = build_dist_table();

endpackage

### hw/rtl/gamma_brightness_contrast_curve.sv
// ----------------------------------------------------------------------------
// gamma_brightness_contrast_curve: pipelined 8-bit to 16-bit transfer curve
// Power law with exponent 1/gamma, then brightness gain, contrast about mid
// scale and clamping; identity level*256 when the curve is disabled.
// ----------------------------------------------------------------------------
// Usage
//   Input: drive req_level and pulse start; a transfer happens on every edge
//   with start high (busy is always low, one level per clock is taken).
//   Output: rsp_valid is high for one cycle with rsp_corrected; results come
//   in input order, the receiver cannot hold them off and none is needed.
//   Throughput: one item per clock. The depth from the accepting edge to the
//   edge that takes the result is set by the chain of 16 square roots of the
//   exp2 unit, resolved two root bits per stage.
//   Config: csr_write writes register csr_index with csr_wdata on the edge;
//   write only while no item is in flight.
//   Reset: synchronous; clears the pipeline valid bits and sets enable = 1,
//   exponent, brightness and contrast = 1.0 (Q3.12).
// ----------------------------------------------------------------------------
module gamma_brightness_contrast_curve (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [gbc_pkg::LEVEL_BITS-1:0]    req_level,
   output logic                              rsp_valid,
   output logic [gbc_pkg::OUT_BITS-1:0]      rsp_corrected,
   input  logic                              csr_write,
   input  logic [gbc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [gbc_pkg::CFG_BITS-1:0]      csr_wdata
);
   import gbc_pkg::*;

   localparam int ID_UP = (OUT_BITS >= LEVEL_BITS) ? OUT_BITS - LEVEL_BITS : 0;
   localparam int ID_DN = (LEVEL_BITS > OUT_BITS) ? LEVEL_BITS - OUT_BITS : 0;
   localparam int ID_W  = LEVEL_BITS + OUT_BITS;
   localparam int IP_BITS = POW_BITS - 16;

   typedef struct packed {
      logic [61:0] rem;
      logic [30:0] root;
   } sq_state_type;

   // One bit of a root; a round starts from the previous root
   function automatic sq_state_type sq_iter(input sq_state_type st,
                                            input logic [POW_BITS-1:0] p,
                                            input int rnd, input int bi);
      sq_state_type o;
      logic [30:0] rp;
      logic [61:0] trial;
      o = st;
      if (bi == SQ_BITS - 1) begin
         rp = (rnd == 0) ? 31'h4000_0000 : st.root;
         if (p[rnd]) rp = rp >> 1;
         o.rem  = {1'b0, rp, 30'd0};
         o.root = '0;
      end
      trial = ({31'd0, o.root} << (bi + 1)) + (62'd1 << (2 * bi));
      if (o.rem >= trial) begin
         o.rem      = o.rem - trial;
         o.root[bi] = 1'b1;
      end
      return o;
   endfunction

   // Configuration registers
   logic                enable_ff;
   logic [CFG_BITS-1:0] exponent_ff, brightness_ff, contrast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b1;
         exponent_ff   <= ONE_Q12;
         brightness_ff <= ONE_Q12;
         contrast_ff   <= ONE_Q12;
      end else if (csr_write) begin
         case (csr_index)
            CFG_ENABLE:     enable_ff     <= csr_wdata[0];
            CFG_EXPONENT:   exponent_ff   <= csr_wdata;
            CFG_BRIGHTNESS: brightness_ff <= csr_wdata;
            CFG_CONTRAST:   contrast_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Stage 0: input register
   logic                  v0_ff;
   logic [LEVEL_BITS-1:0] lvl0_ff;
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else v0_ff <= start & ~busy;
      lvl0_ff <= req_level;
   end

   // Stage 1: log distance lookup
   logic                  v1_ff;
   logic [LEVEL_BITS-1:0] lvl1_ff;
   logic [DIST_BITS-1:0]  dist1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= v0_ff;
      lvl1_ff  <= lvl0_ff;
      dist1_ff <= DIST_TABLE[lvl0_ff];
   end

   // Square-root chain carriers; index 0 is the power register
   logic                  sq_v_ff   [SQ_STAGES+1];
   logic [LEVEL_BITS-1:0] sq_lvl_ff [SQ_STAGES+1];
   logic [POW_BITS-1:0]   sq_p_ff   [SQ_STAGES+1];
   sq_state_type          sq_st_ff  [SQ_STAGES+1];

   // Stage 2: power P = (L * exponent) >> 12
   logic [DIST_BITS+CFG_BITS-1:0] pow_in;
   assign pow_in = (DIST_BITS+CFG_BITS)'(dist1_ff) * (DIST_BITS+CFG_BITS)'(exponent_ff);

   always_ff @(posedge clock) begin
      if (reset) sq_v_ff[0] <= 1'b0;
      else sq_v_ff[0] <= v1_ff;
      sq_lvl_ff[0] <= lvl1_ff;
      sq_p_ff[0]   <= pow_in[DIST_BITS+CFG_BITS-1:12];
      sq_st_ff[0]  <= '0;
   end

   // exp2 unit: 16 square roots, two root bits per stage
   for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sq
      localparam int T0 = SQ_PER_STAGE * g;
      localparam int T1 = T0 + 1;
      localparam int R0 = T0 / SQ_BITS;
      localparam int B0 = SQ_BITS - 1 - (T0 % SQ_BITS);
      localparam int R1 = T1 / SQ_BITS;
      localparam int B1 = SQ_BITS - 1 - (T1 % SQ_BITS);
      sq_state_type st_mid, st_in;

      always_comb begin
         st_mid = sq_iter(sq_st_ff[g], sq_p_ff[g], R0, B0);
         st_in  = sq_iter(st_mid, sq_p_ff[g], R1, B1);
      end

      always_ff @(posedge clock) begin
         if (reset) sq_v_ff[g+1] <= 1'b0;
         else sq_v_ff[g+1] <= sq_v_ff[g];
         sq_lvl_ff[g+1] <= sq_lvl_ff[g];
         sq_p_ff[g+1]   <= sq_p_ff[g];
         sq_st_ff[g+1]  <= st_in;
      end
   end

   // Integer shift of the power and special cases
   logic [IP_BITS-1:0]    ip;
   logic [30:0]           rsh;
   logic [16:0]           y_in;
   logic                  vy_ff;
   logic [LEVEL_BITS-1:0] lvly_ff;
   logic [16:0]           y_ff;

   always_comb begin
      ip  = sq_p_ff[SQ_STAGES][POW_BITS-1:16];
      rsh = (ip >= IP_BITS'(31)) ? '0 : (sq_st_ff[SQ_STAGES].root >> ip);
      if (exponent_ff == '0) y_in = 17'h10000;
      else if (sq_lvl_ff[SQ_STAGES] == '0) y_in = '0;
      else y_in = rsh[30:14];
   end

   always_ff @(posedge clock) begin
      if (reset) vy_ff <= 1'b0;
      else vy_ff <= sq_v_ff[SQ_STAGES];
      lvly_ff <= sq_lvl_ff[SQ_STAGES];
      y_ff    <= y_in;
   end

   // Brightness gain
   logic [31:0]           bmul;
   logic                  vb_ff;
   logic [LEVEL_BITS-1:0] lvlb_ff;
   logic [19:0]           b_ff;
   assign bmul = 32'(y_ff) * 32'(brightness_ff);

   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else vb_ff <= vy_ff;
      lvlb_ff <= lvly_ff;
      b_ff    <= bmul[31:12];
   end

   // Contrast about mid scale
   logic signed [20:0]    d;
   logic signed [36:0]    prod_in;
   logic                  vc_ff;
   logic [LEVEL_BITS-1:0] lvlc_ff;
   logic signed [36:0]    prod_ff;

   always_comb begin
      d       = $signed({1'b0, b_ff}) - 21'sd32768;
      prod_in = 37'(d) * 37'($signed({1'b0, contrast_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else vc_ff <= vb_ff;
      lvlc_ff <= lvlb_ff;
      prod_ff <= prod_in;
   end

   // Floor shift, clamp, scale; identity when disabled
   logic signed [24:0]    c_sh;
   logic [16:0]           c_cl;
   logic [16+OUT_BITS-1:0] scaled;
   logic [ID_W-1:0]       id_wide;
   logic [OUT_BITS-1:0]   out_in;
   logic                  rsp_valid_ff;
   logic [OUT_BITS-1:0]   rsp_corrected_ff;

   always_comb begin
      c_sh = 25'(prod_ff >>> 12) + 25'sd32768;
      if (c_sh < 0) c_cl = '0;
      else if (c_sh > 25'sd65536) c_cl = 17'h10000;
      else c_cl = c_sh[16:0];
      scaled  = (16+OUT_BITS)'(c_cl) * (16+OUT_BITS)'({OUT_BITS{1'b1}});
      id_wide = (ID_W'(lvlc_ff) << ID_UP) >> ID_DN;
      out_in  = enable_ff ? scaled[16+OUT_BITS-1:16] : id_wide[OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= vc_ff;
      rsp_corrected_ff <= out_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_corrected = rsp_corrected_ff;

endmodule

### hw/rtl/gbc_checker.sv
// ----------------------------------------------------------------------------
// gbc_checker: port-level checks for the transfer curve
// Watches the command and result ports for strobe timing and reset behavior.
// ----------------------------------------------------------------------------
module gbc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [gbc_pkg::OUT_BITS-1:0]   rsp_corrected
);
   import gbc_pkg::*;

   // The pipeline never refuses a transfer
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // Every result strobe traces back to an accepted command
   a_rsp_from_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, RSP_LATENCY))
      else $error("result strobe without matching command");

   // Reset empties the pipeline
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // Result data is never unknown on a strobe
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_corrected))
      else $error("unknown result data");

endmodule

bind gamma_brightness_contrast_curve gbc_checker u_gbc_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_corrected (rsp_corrected)
);

### verif/tb_gamma_brightness_contrast_curve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gamma_brightness_contrast_curve: regression for the transfer curve
// Drives levels through the start/busy port under several register settings,
// computes each expected curve value in the bench and compares it with the
// strobed result, oldest first.
// ----------------------------------------------------------------------------
module tb_gamma_brightness_contrast_curve;
   import gbc_pkg::*;

   localparam int WATCHDOG_LIMIT = 4 * RSP_LATENCY + 2000;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [LEVEL_BITS-1:0]   req_level;
   logic                    rsp_valid;
   logic [OUT_BITS-1:0]     rsp_corrected;
   logic                    csr_write;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]     csr_wdata;

   gamma_brightness_contrast_curve i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_level     (req_level),
      .rsp_valid     (rsp_valid),
      .rsp_corrected (rsp_corrected),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // Bench copy of the registers
   logic                curve_on;
   logic [CFG_BITS-1:0] gamma_exp;
   logic [CFG_BITS-1:0] bright_gain;
   logic [CFG_BITS-1:0] contrast_gain;

   logic [OUT_BITS-1:0] corrected_q[$];
   int unsigned idle_pct;
   int unsigned mismatches;
   int unsigned levels_sent;
   int unsigned results_seen;
   int unsigned settings_used;
   int unsigned quiet_cycles;
   bit          failed;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // log2 in Q.16 by successive squaring
   function automatic logic [31:0] log2_fix(input logic [31:0] v);
      logic [31:0] n;
      logic [63:0] m;
      logic [15:0] fr;
      n  = 0;
      fr = '0;
      while (n < 31 && (v >> (n + 1)) != 0) n++;
      m = ({32'd0, v} << 16) >> n;
      for (int k = 0; k < 16; k++) begin
         m  = (m * m) >> 16;
         fr = {fr[14:0], 1'b0};
         if (m >= 64'h20000) begin
            fr[0] = 1'b1;
            m = m >> 1;
         end
      end
      return (n << 16) | {16'd0, fr};
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = '0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // 2^(-p), p in Q.16, result in Q.30
   function automatic logic [63:0] exp2_neg(input logic [63:0] p);
      logic [63:0] r;
      logic [63:0] ip;
      r  = 64'd1 << 30;
      ip = p >> 16;
      for (int k = 0; k < 16; k++) begin
         if (p[k]) r = r >> 1;
         r = int_sqrt(r << 30);
      end
      if (ip >= 31) return '0;
      return r >> ip;
   endfunction

   function automatic logic [OUT_BITS-1:0] curve_value(input logic [LEVEL_BITS-1:0] lvl);
      logic [63:0] y;
      logic [63:0] log_gap;
      logic [63:0] pw;
      logic [31:0] lm;
      logic [31:0] ll;
      longint      b;
      longint      prod;
      longint      c;
      logic [63:0] scaled;
      if (!curve_on) return {lvl, 8'd0};
      if (gamma_exp == 0) begin
         y = 64'd65536;
      end else if (lvl == 0) begin
         y = '0;
      end else begin
         lm      = log2_fix(LEVEL_MAX);
         ll      = log2_fix({24'd0, lvl});
         log_gap = (lm > ll) ? {32'd0, lm - ll} : 64'd0;
         pw      = (log_gap * gamma_exp) >> 12;
         y       = exp2_neg(pw) >> 14;
      end
      b    = longint'((y * bright_gain) >> 12);
      prod = (b - 32768) * longint'(contrast_gain);
      if (prod >= 0) c = prod / 4096;
      else c = -((-prod + 4095) / 4096);
      c = c + 32768;
      if (c < 0) c = 0;
      if (c > 65536) c = 65536;
      scaled = (64'(c) * 65535) >> 16;
      return scaled[OUT_BITS-1:0];
   endfunction

   // Edge sampling: register writes, accepted levels, result check, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write) begin
            case (csr_index)
               CFG_ENABLE:     curve_on      = csr_wdata[0];
               CFG_EXPONENT:   gamma_exp     = csr_wdata;
               CFG_BRIGHTNESS: bright_gain   = csr_wdata;
               CFG_CONTRAST:   contrast_gain = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            results_seen++;
            if (corrected_q.size() == 0) begin
               failed = 1'b1;
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: corrected=%0d", rsp_corrected);
            end else begin
               if (rsp_corrected !== corrected_q[0]) begin
                  failed = 1'b1;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: corrected expected %0d actual %0d",
                              corrected_q[0], rsp_corrected);
               end
               void'(corrected_q.pop_front());
            end
         end
         if (start && !busy) begin
            corrected_q.push_back(curve_value(req_level));
            levels_sent++;
         end
         if (rsp_valid || (start && !busy)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("gamma_brightness_contrast_curve regression: fail");
            $finish;
         end
      end
   end

   // One level transfer, with random idle cycles ahead of it
   task automatic send_level(input logic [LEVEL_BITS-1:0] lvl);
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start     <= 1'b1;
      req_level <= lvl;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Lower start and wait until every expected result has come
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (corrected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CFG_BITS-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_curve(input logic [CFG_BITS-1:0] en_word,
                            input logic [CFG_BITS-1:0] ex,
                            input logic [CFG_BITS-1:0] br,
                            input logic [CFG_BITS-1:0] ct);
      drain();
      write_reg(CFG_ENABLE, en_word);
      write_reg(CFG_EXPONENT, ex);
      write_reg(CFG_BRIGHTNESS, br);
      write_reg(CFG_CONTRAST, ct);
      settings_used++;
   endtask

   // Reset values: unity curve on black, mid and full levels
   task automatic test_reset_defaults();
      send_level(8'd0);
      send_level(8'd1);
      send_level(8'd127);
      send_level(8'd128);
      send_level(8'd254);
      send_level(8'd255);
      drain();
   endtask

   // Curve off gives the identity; upper data bits of enable are ignored
   task automatic test_identity();
      set_curve(15'h7FFE, ONE_Q12, ONE_Q12, ONE_Q12);
      send_level(8'd0);
      send_level(8'd85);
      send_level(8'd170);
      send_level(8'd255);
      drain();
   endtask

   // Register extremes, exponent zero and small nonzero exponents
   task automatic test_extremes();
      set_curve(15'h7FFF, 15'd0, ONE_Q12, ONE_Q12);
      send_level(8'd0);
      send_level(8'd200);
      set_curve(15'd1, 15'd1, ONE_Q12, ONE_Q12);
      send_level(8'd0);
      send_level(8'd3);
      set_curve(15'd1, 15'd512, 15'd0, 15'd32767);
      send_level(8'd255);
      send_level(8'd64);
      set_curve(15'd1, 15'd32767, 15'd32767, 15'd0);
      send_level(8'd1);
      send_level(8'd255);
      set_curve(15'd1, 15'd32767, 15'd32767, 15'd32767);
      send_level(8'd2);
      send_level(8'd250);
      set_curve(15'd1, 15'd512, 15'd32767, 15'd32767);
      send_level(8'd1);
      send_level(8'd128);
      drain();
   endtask

   function automatic logic [CFG_BITS-1:0] pick_gain(input int unsigned lo);
      case ($urandom_range(0, 3))
         0:       return CFG_BITS'($urandom_range(lo, 32767));
         1:       return CFG_BITS'($urandom_range(lo, 32767));
         default: return CFG_BITS'($urandom_range(2048, 8192));
      endcase
   endfunction

   // Random levels in blocks, a new random setting between blocks
   task automatic test_random_curve(input int unsigned pct, input int unsigned count);
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            set_curve(($urandom_range(0, 7) == 0) ? CFG_BITS'($urandom) & 15'h7FFE
                                                  : CFG_BITS'($urandom) | 15'd1,
                      pick_gain(512), pick_gain(0), pick_gain(0));
         end
         send_level(LEVEL_BITS'($urandom));
      end
      drain();
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_level     = '0;
      csr_write     = 1'b0;
      csr_index     = CFG_ENABLE;
      csr_wdata     = '0;
      curve_on      = 1'b1;
      gamma_exp     = ONE_Q12;
      bright_gain   = ONE_Q12;
      contrast_gain = ONE_Q12;
      idle_pct      = 0;
      mismatches    = 0;
      levels_sent   = 0;
      results_seen  = 0;
      settings_used = 1;
      quiet_cycles  = 0;
      failed        = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_identity();
      test_extremes();
      test_random_curve(38, 170);
      test_random_curve(66, 170);
      test_random_curve(0, 170);

      drain();
      repeat (RSP_LATENCY + 20) @(posedge clock);
      $display("covered %0d levels and %0d results over %0d register settings",
               levels_sent, results_seen, settings_used);
      $display("identity, exponent zero and extremes, random curves; %0d mismatches",
               mismatches);
      if (!failed && corrected_q.size() == 0) begin
         $display("gamma_brightness_contrast_curve regression: pass");
      end else begin
         $display("gamma_brightness_contrast_curve regression: fail");
      end
      $finish;
   end

endmodule
